FILE: src/vpid_pkg.sv
package vpid_pkg;

   localparam int Q_W     = 32;
   localparam int STEP_W  = 31;
   localparam int CMD_W   = 18;
   localparam int FRAC_W  = 16;
   localparam int REQ_W   = 64;
   localparam int RSP_W   = 24;
   localparam int CSR_IDX_W = 3;

   typedef logic signed [Q_W-1:0] q_type;

   localparam q_type Q_MAX     = 32'sh7fff_ffff;
   localparam q_type Q_MIN     = 32'sh8000_0000;
   localparam q_type VEL_LIMIT = 32'sd102944;

   localparam logic [STEP_W-1:0] TIME_STEP_RST     = 31'd655;
   localparam logic [STEP_W-1:0] INV_TIME_STEP_RST = 31'd6553600;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_TIME_STEP = 3'd4;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_TP,
      ST_ADD_TP,
      ST_ERR,
      ST_MUL_P,
      ST_ACC_P,
      ST_MUL_I,
      ST_ACC_I,
      ST_MUL_IG,
      ST_ACC_IG,
      ST_DIFF,
      ST_MUL_D1,
      ST_STORE_D1,
      ST_MUL_D2,
      ST_ACC_D,
      ST_MUL_OUT,
      ST_CLAMP
   } state_type;

   function automatic q_type sat_add(q_type a, q_type b);
      logic signed [Q_W:0] s;
      s = {a[Q_W-1], a} + {b[Q_W-1], b};
      if (s[Q_W] != s[Q_W-1]) begin
         return s[Q_W] ? Q_MIN : Q_MAX;
      end
      return s[Q_W-1:0];
   endfunction

   function automatic q_type sat_sub(q_type a, q_type b);
      logic signed [Q_W:0] s;
      s = {a[Q_W-1], a} - {b[Q_W-1], b};
      if (s[Q_W] != s[Q_W-1]) begin
         return s[Q_W] ? Q_MIN : Q_MAX;
      end
      return s[Q_W-1:0];
   endfunction

endpackage

FILE: src/vpid_mul.sv
module vpid_mul (
   input  logic                  clock,
   input  vpid_pkg::q_type       mul_a,
   input  vpid_pkg::q_type       mul_b,
   output vpid_pkg::q_type       mul_q
);
   import vpid_pkg::*;

   logic signed [2*Q_W-1:0] prod_ff;
   logic signed [2*Q_W-1:0] prod_in;
   logic signed [2*Q_W-FRAC_W-1:0] shifted;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // arithmetic shift floors toward minus infinity
   assign shifted = prod_ff[2*Q_W-1:FRAC_W];

   always_comb begin
      if (shifted[2*Q_W-FRAC_W-1:Q_W-1] == '0 ||
          shifted[2*Q_W-FRAC_W-1:Q_W-1] == '1) begin
         mul_q = shifted[Q_W-1:0];
      end else if (shifted[2*Q_W-FRAC_W-1]) begin
         mul_q = Q_MIN;
      end else begin
         mul_q = Q_MAX;
      end
   end

endmodule

FILE: src/velocity_pid_controller.sv
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tdata: measured_pos, target_vel
// rsp     | out | rsp_tvalid/tready    | tdata: velocity_cmd; tuser: clamped
// csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// items run one at a time; the first after reset skips the derivative steps; a shared
// 32x32 multiplier with a registered product runs up to seven multiplies in turn
// req_tready is high only while the sequencer is idle
// the result sits in an output register; the next item is taken while it waits
// a stalled rsp holds the sequencer in its last step
// reset is synchronous, active high, and reseeds the target on the next item
module velocity_pid_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [vpid_pkg::REQ_W-1:0]        req_tdata,  // measured_pos, target_vel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [vpid_pkg::RSP_W-1:0]        rsp_tdata,  // velocity_cmd, zero pad
   output logic                              rsp_tuser,  // clamped
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vpid_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vpid_pkg::Q_W-1:0]          csr_data
);
   import vpid_pkg::*;

   state_type state_ff, state_in;

   q_type gain_p_ff, gain_i_ff, gain_d_ff;
   logic [STEP_W-1:0] ts_ff, its_ff;

   q_type pos_ff, pos_in, vel_ff, vel_in;
   q_type tp_ff, tp_in, integ_ff, integ_in, prev_ff, prev_in;
   logic  first_ff, first_in;
   q_type err_ff, err_in, ctrl_ff, ctrl_in, tmp_ff, tmp_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic              clamp_ff, clamp_in;

   q_type mul_a, mul_b, mul_q;
   q_type ts_q, its_q;
   logic  req_xfer, rsp_xfer, out_free;

   assign ts_q  = {1'b0, ts_ff};
   assign its_q = {1'b0, its_ff};

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign rsp_xfer   = rsp_valid_ff & rsp_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-CMD_W){1'b0}}, cmd_ff};
   assign rsp_tuser  = clamp_ff;

   vpid_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_q (mul_q)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         ts_ff     <= TIME_STEP_RST;
         its_ff    <= INV_TIME_STEP_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN_P:        gain_p_ff <= csr_data;
            CSR_GAIN_I:        gain_i_ff <= csr_data;
            CSR_GAIN_D:        gain_d_ff <= csr_data;
            CSR_TIME_STEP:     ts_ff     <= csr_data[STEP_W-1:0];
            CSR_INV_TIME_STEP: its_ff    <= csr_data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_xfer) state_in = ST_MUL_TP;
         ST_MUL_TP:   state_in = ST_ADD_TP;
         ST_ADD_TP:   state_in = ST_ERR;
         ST_ERR:      state_in = ST_MUL_P;
         ST_MUL_P:    state_in = ST_ACC_P;
         ST_ACC_P:    state_in = ST_MUL_I;
         ST_MUL_I:    state_in = ST_ACC_I;
         ST_ACC_I:    state_in = ST_MUL_IG;
         ST_MUL_IG:   state_in = ST_ACC_IG;
         ST_ACC_IG:   state_in = first_ff ? ST_MUL_OUT : ST_DIFF;
         ST_DIFF:     state_in = ST_MUL_D1;
         ST_MUL_D1:   state_in = ST_STORE_D1;
         ST_STORE_D1: state_in = ST_MUL_D2;
         ST_MUL_D2:   state_in = ST_ACC_D;
         ST_ACC_D:    state_in = ST_MUL_OUT;
         ST_MUL_OUT:  state_in = ST_CLAMP;
         ST_CLAMP:    if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_TP:  begin mul_a = vel_ff;   mul_b = ts_q;      end
         ST_MUL_P:   begin mul_a = err_ff;   mul_b = gain_p_ff; end
         ST_MUL_I:   begin mul_a = err_ff;   mul_b = ts_q;      end
         ST_MUL_IG:  begin mul_a = integ_ff; mul_b = gain_i_ff; end
         ST_MUL_D1:  begin mul_a = tmp_ff;   mul_b = gain_d_ff; end
         ST_MUL_D2:  begin mul_a = tmp_ff;   mul_b = its_q;     end
         ST_MUL_OUT,
         ST_CLAMP:   begin mul_a = ctrl_ff;  mul_b = its_q;     end
         default: ;
      endcase
   end

   // datapath updates
   always_comb begin
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      tp_in        = tp_ff;
      integ_in     = integ_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      err_in       = err_ff;
      ctrl_in      = ctrl_ff;
      tmp_in       = tmp_ff;
      cmd_in       = cmd_ff;
      clamp_in     = clamp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_xfer;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               pos_in = req_tdata[Q_W-1:0];
               vel_in = req_tdata[2*Q_W-1:Q_W];
            end
         end
         ST_ADD_TP:   tp_in = sat_add(first_ff ? pos_ff : tp_ff, mul_q);
         ST_ERR:      err_in = sat_sub(tp_ff, pos_ff);
         ST_ACC_P:    ctrl_in = mul_q;
         ST_ACC_I: begin
            if (gain_i_ff != '0) begin
               integ_in = sat_add(first_ff ? '0 : integ_ff, mul_q);
            end else begin
               integ_in = '0;
            end
         end
         ST_ACC_IG:   ctrl_in = sat_add(ctrl_ff, mul_q);
         ST_DIFF:     tmp_in = sat_sub(err_ff, prev_ff);
         ST_STORE_D1: tmp_in = mul_q;
         ST_ACC_D:    ctrl_in = sat_add(ctrl_ff, mul_q);
         ST_MUL_OUT: begin
            prev_in  = err_ff;
            first_in = 1'b0;
         end
         ST_CLAMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (mul_q > VEL_LIMIT) begin
                  cmd_in   = VEL_LIMIT[CMD_W-1:0];
                  clamp_in = 1'b1;
               end else if (mul_q < -VEL_LIMIT) begin
                  cmd_in   = 18'(-VEL_LIMIT);
                  clamp_in = 1'b1;
               end else begin
                  cmd_in   = mul_q[CMD_W-1:0];
                  clamp_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   // the product register holds the last multiply while CLAMP stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tp_ff        <= '0;
         integ_ff     <= '0;
         prev_ff      <= '0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tp_ff        <= tp_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      vel_ff   <= vel_in;
      err_ff   <= err_in;
      ctrl_ff  <= ctrl_in;
      tmp_ff   <= tmp_in;
      cmd_ff   <= cmd_in;
      clamp_ff <= clamp_in;
   end

   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_MUL_TP)
      else $error("accepted transfer did not start the sequencer");

   a_rsp_from_clamp : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_CLAMP)
      else $error("result raised outside the final step");

   a_flag_at_limit : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && clamp_ff) |->
         (cmd_ff == VEL_LIMIT[CMD_W-1:0] || cmd_ff == 18'(-VEL_LIMIT)))
      else $error("clamp flag set with command off the limit");

   a_first_clear : assert property (@(posedge clock) disable iff (reset)
      $fell(first_ff) |-> $past(state_ff) == ST_MUL_OUT)
      else $error("first-step flag cleared at the wrong step");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import vpid_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS = 250;

   typedef struct {
      q_type pos;
      q_type vel;
   } joint_sample_type;

   typedef struct {
      logic signed [CMD_W-1:0] cmd;
      logic                    clamp;
   } cmd_result_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [Q_W-1:0]       csr_data = '0;

   velocity_pid_controller DUT (.*);

   joint_sample_type sample_q[$];
   cmd_result_type   cmd_expect_q[$];
   bit          calm = 1'b0;
   int          fails = 0;
   int          quiet_cycles = 0;
   int          stall_left = 0;
   int          rsp_xfers = 0;
   longint      walk_pos = 0;

   // predictor copy of registers and loop state
   longint kp_reg = 0;
   longint ki_reg = 0;
   longint kd_reg = 0;
   longint ts_reg = TIME_STEP_RST;
   longint inv_reg = INV_TIME_STEP_RST;
   longint tgt_pos = 0;
   longint integ_acc = 0;
   longint prev_err = 0;
   bit     seed_pending = 1'b1;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint sat_q(longint v);
      if (v > longint'(Q_MAX)) return Q_MAX;
      if (v < longint'(Q_MIN)) return Q_MIN;
      return v;
   endfunction

   // floor of the q16.16 product, then saturated
   function automatic longint mul_q(longint a, longint b);
      return sat_q((a * b) >>> FRAC_W);
   endfunction

   function automatic cmd_result_type pid_step(q_type pos_in, q_type vel_in);
      longint pos, vel, err, ctrl, cmd;
      cmd_result_type r;
      pos = pos_in;
      vel = vel_in;
      if (seed_pending) begin
         integ_acc = 0;
         tgt_pos = pos;
      end
      tgt_pos = sat_q(tgt_pos + mul_q(vel, ts_reg));
      err = sat_q(tgt_pos - pos);
      ctrl = mul_q(err, kp_reg);
      integ_acc = (ki_reg != 0) ? sat_q(integ_acc + mul_q(err, ts_reg)) : 0;
      ctrl = sat_q(ctrl + mul_q(integ_acc, ki_reg));
      if (!seed_pending) begin
         ctrl = sat_q(ctrl + mul_q(mul_q(sat_q(err - prev_err), kd_reg), inv_reg));
      end
      prev_err = err;
      seed_pending = 1'b0;
      cmd = mul_q(ctrl, inv_reg);
      r.clamp = (cmd > VEL_LIMIT) || (cmd < -VEL_LIMIT);
      if (cmd > VEL_LIMIT) begin
         cmd = VEL_LIMIT;
      end else if (cmd < -VEL_LIMIT) begin
         cmd = -VEL_LIMIT;
      end
      r.cmd = cmd[CMD_W-1:0];
      return r;
   endfunction

   function automatic q_type rnd_q(int unsigned mag);
      return q_type'(longint'($urandom_range(0, 2 * mag)) - longint'(mag));
   endfunction

   function automatic logic [31:0] recip_q(logic [31:0] step);
      longint r;
      r = 64'sh1_0000_0000 / longint'(step);
      return (r > longint'(Q_MAX)) ? Q_MAX : r[31:0];
   endfunction

   // sender
   always @(posedge clock) begin : drive_req
      joint_sample_type s;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (sample_q.size() != 0 && (calm || $urandom_range(0, 99) >= 21)) begin
            s = sample_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {s.vel, s.pos};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with a long hold-off now and then so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_xfers++;
            if (rsp_xfers % 600 == 300) stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(0, 99) >= 21);
         end
      end
   end

   always @(posedge clock) begin : watch_ports
      cmd_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN_P: kp_reg = q_type'(csr_data);
               CSR_GAIN_I: ki_reg = q_type'(csr_data);
               CSR_GAIN_D: kd_reg = q_type'(csr_data);
               CSR_TIME_STEP: ts_reg = csr_data[STEP_W-1:0];
               CSR_INV_TIME_STEP: inv_reg = csr_data[STEP_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            cmd_expect_q.push_back(pid_step(q_type'(req_tdata[Q_W-1:0]),
                                            q_type'(req_tdata[REQ_W-1:Q_W])));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (cmd_expect_q.size() == 0) begin
               $error("command transfer with no command expected");
               fails++;
            end else begin
               want = cmd_expect_q.pop_front();
               if (rsp_tdata[CMD_W-1:0] !== want.cmd) begin
                  $error("velocity_cmd expected %0d got %0d", want.cmd,
                         $signed(rsp_tdata[CMD_W-1:0]));
                  fails++;
               end
               if (rsp_tuser !== want.clamp) begin
                  $error("clamped expected %0d got %0d", want.clamp, rsp_tuser);
                  fails++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("velocity_pid_controller regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [Q_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_regs(q_type p_gain, q_type i_gain, q_type d_gain,
                             logic [31:0] step, logic [31:0] inv_step,
                             logic [CSR_IDX_W-1:0] spare_idx);
      @(posedge clock);
      csr_write(CSR_GAIN_P, p_gain);
      csr_write(CSR_GAIN_I, i_gain);
      csr_write(CSR_GAIN_D, d_gain);
      csr_write(CSR_TIME_STEP, step);
      csr_write(CSR_INV_TIME_STEP, inv_step);
      csr_write(spare_idx, $urandom);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_and_wait();
      while (sample_q.size() != 0 || req_tvalid || cmd_expect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly a wandering joint with modest speed requests, some raw noise
   task automatic queue_random(int n);
      joint_sample_type s;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 99) < 5) walk_pos = rnd_q(1 << 20);
            walk_pos += rnd_q(8192);
            if (walk_pos > 393216) walk_pos = 393216;
            if (walk_pos < -393216) walk_pos = -393216;
            s.pos = q_type'(walk_pos);
            s.vel = rnd_q(1 << 18);
         end else begin
            s.pos = q_type'($urandom);
            s.vel = q_type'($urandom);
         end
         sample_q.push_back(s);
      end
   endtask

   initial begin : run_test
      longint      trk;
      q_type       lim_err [5];
      q_type       kp_w, ki_w, kd_w;
      logic [31:0] ts_w, inv_w;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // unit P gain, zero I and D gains, unit period: the command equals the position error
      write_regs(32'sd65536, 32'sd0, 32'sd0, 32'd65536, 32'd65536,
                 CSR_INV_TIME_STEP + 3'd1);
      lim_err[0] = VEL_LIMIT;
      lim_err[1] = VEL_LIMIT + 1;
      lim_err[2] = -VEL_LIMIT;
      lim_err[3] = -VEL_LIMIT - 1;
      lim_err[4] = 0;
      trk = 1000;
      sample_q.push_back('{q_type'(trk), q_type'(0)});
      foreach (lim_err[k]) begin
         trk += 5;
         sample_q.push_back('{q_type'(trk - lim_err[k]), q_type'(5)});
      end
      sample_q.push_back('{Q_MAX, Q_MAX});
      sample_q.push_back('{Q_MIN, Q_MIN});
      sample_q.push_back('{Q_MIN, Q_MAX});
      sample_q.push_back('{Q_MAX, Q_MIN});
      sample_q.push_back('{q_type'(0), q_type'(0)});
      sample_q.push_back('{q_type'(-1), q_type'(-1)});
      drain_and_wait();

      for (int p = 0; p < 8; p++) begin
         kp_w = rnd_q(1 << 18);
         ki_w = rnd_q(1 << 16);
         kd_w = rnd_q(1 << 12);
         ts_w = $urandom_range(16, 65536);
         inv_w = recip_q(ts_w);
         case (p)
            1: begin
               kp_w = $urandom;
               ki_w = $urandom;
               kd_w = $urandom;
               ts_w = $urandom;
               inv_w = $urandom;
            end
            2: begin
               kp_w = Q_MAX;
               ki_w = Q_MAX;
               kd_w = Q_MAX;
               ts_w = 32'hffff_ffff;
               inv_w = 32'hffff_ffff;
            end
            3: begin
               ts_w = 32'd0;
               inv_w = $urandom_range(1, 1 << 20);
            end
            5: begin
               kp_w = Q_MIN;
               ki_w = Q_MIN;
               kd_w = Q_MIN;
               ts_w = 32'd1;
               inv_w = 32'd1;
            end
            6: inv_w = 32'd0;
            7: ki_w = 32'sd0;
            default: ;
         endcase
         write_regs(kp_w, ki_w, kd_w, ts_w, inv_w, CSR_INV_TIME_STEP + 3'(1 + p % 3));
         calm = (p == 4);
         queue_random(PHASE_ITEMS);
         drain_and_wait();
      end
      calm = 1'b0;

      if (fails == 0) begin
         $display("velocity_pid_controller regression: pass");
      end else begin
         $display("velocity_pid_controller regression: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/vpid_pkg.sv
src/vpid_mul.sv
src/velocity_pid_controller.sv
bench/testbench.sv
